FILE: rtl/ecfr_pkg.sv
// Package for the escaped command frame receiver.
// Frame delimiters, escape codes, status codes and configuration defaults.
// No dependencies.
`default_nettype none

package ecfr_pkg;

    // Frame delimiters and escape handling
    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] END_BYTE   = 8'h7F;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_TO_7E  = 8'h5E;
    localparam logic [7:0] ESC_TO_7F  = 8'h5F;
    localparam logic [7:0] ESC_TO_7D  = 8'h5D;

    // Configuration
    localparam int          CFG_W            = 5;
    localparam int          MAX_COUNT_DEF    = 31;
    localparam logic [CFG_W-1:0] MIN_LEN_RESET = 5'd6;
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 5'd9;

    localparam logic CFG_MIN_LEN = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    // Payload bytes kept per frame
    localparam int PAY_N = 4;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LEN    = 3'd1,
        ST_BAD_DELIM  = 3'd2,
        ST_BAD_ESC    = 3'd3,
        ST_TOO_FEW    = 3'd4,
        ST_BAD_CHKSUM = 3'd5
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/escaped_command_frame_receiver_top.sv
// Escaped command frame receiver: unstuffs a byte stream and reports each frame.
// Depends on ecfr_pkg.
// A frame's registered result appears in the cycle after its end-of-frame beat.
// Throughput: one byte beat per cycle unless a stalled result holds s_ready low;
// the per-byte state update is a single pass. Reset: aresetn (synchronous, active
// low) clears frame state, limits to 6 and 9, and drops any pending result.
`default_nettype none

module escaped_command_frame_receiver_top #(
    parameter int MAX_COUNT = ecfr_pkg::MAX_COUNT_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    // configuration write port
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_index,
    input  wire logic [ecfr_pkg::CFG_W-1:0]  cfg_data,

    // raw byte stream
    input  wire logic                        s_valid,
    output      logic                        s_ready,
    input  wire logic [7:0]                  s_rx_byte,
    input  wire logic                        s_end_of_frame,

    // frame result
    output      logic                        m_valid,
    input  wire logic                        m_ready,
    output      logic [2:0]                  m_status,
    output      logic [7:0]                  m_command_code,
    output      logic [7:0]                  m_command_arg,
    output      logic [7:0]                  m_extra_byte,
    output      logic [7:0]                  m_check_byte
);
    import ecfr_pkg::*;

    // raw count saturates at MAX_COUNT
    localparam int CNT_W = $clog2(MAX_COUNT + 1);
    // common width for comparing the count against the limits
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COUNT);

    // limit registers
    logic [CFG_W-1:0] min_len_reg, max_len_reg;

    // per-frame state
    logic [CNT_W-1:0] raw_count_reg,      raw_count_next;
    logic [7:0]       held_byte_reg,      held_byte_next;
    logic             esc_pending_reg,    esc_pending_next;
    logic             start_ok_reg,       start_ok_next;
    logic             esc_fault_reg,      esc_fault_next;
    logic [2:0]       dec_count_reg,      dec_count_next;
    logic [7:0]       payload_reg [PAY_N], payload_next [PAY_N];

    // result register
    logic             m_valid_reg;
    status_t          status_reg,         status_next;
    logic [7:0]       res_reg [PAY_N];

    logic             s_beat;
    logic             m_beat;

    // Output register: a new byte is taken whenever the result slot is free
    // or being emptied in this same cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;
    assign m_beat  = m_valid_reg && m_ready;

    // Next frame state and verdict for the current beat. The byte held from
    // the previous beat is decoded only once a further byte proves it interior.
    always_comb begin
        logic       keep;
        logic [7:0] keep_val;
        logic [7:0] sum;
        logic       fault_at_end;
        logic [CMP_W-1:0] cnt_w, min_w, max_w;

        keep     = 1'b0;
        keep_val = held_byte_reg;

        raw_count_next   = raw_count_reg;
        held_byte_next   = held_byte_reg;
        esc_pending_next = esc_pending_reg;
        start_ok_next    = start_ok_reg;
        esc_fault_next   = esc_fault_reg;
        dec_count_next   = dec_count_reg;
        for (int i = 0; i < PAY_N; i++) begin
            payload_next[i] = payload_reg[i];
        end
        status_next = ST_OK;

        if (raw_count_reg == '0) begin
            start_ok_next = (s_rx_byte == START_BYTE);
        end else if (raw_count_reg >= CNT_W'(2)) begin
            if (!esc_fault_reg) begin
                if (esc_pending_reg) begin
                    esc_pending_next = 1'b0;
                    case (held_byte_reg)
                        ESC_TO_7E: begin keep = 1'b1; keep_val = START_BYTE; end
                        ESC_TO_7F: begin keep = 1'b1; keep_val = END_BYTE;   end
                        ESC_TO_7D: begin keep = 1'b1; keep_val = ESC_BYTE;   end
                        default:   esc_fault_next = 1'b1;
                    endcase
                end else if (held_byte_reg == ESC_BYTE) begin
                    esc_pending_next = 1'b1;
                end else begin
                    keep = 1'b1;
                end
            end
        end

        if (keep && dec_count_reg < 3'(PAY_N)) begin
            payload_next[dec_count_reg[1:0]] = keep_val;
            dec_count_next = dec_count_reg + 3'd1;
        end

        if (raw_count_reg != CNT_MAX) begin
            raw_count_next = raw_count_reg + CNT_W'(1);
        end
        held_byte_next = s_rx_byte;

        // An escape left open at the closing byte is a fault; verdict only,
        // the stored fault flag is untouched on interior beats.
        fault_at_end = esc_fault_next || esc_pending_next;

        sum   = payload_next[0] + payload_next[1] + payload_next[2];
        cnt_w = CMP_W'(raw_count_next);
        min_w = CMP_W'(min_len_reg);
        max_w = CMP_W'(max_len_reg);

        if (cnt_w < min_w || cnt_w > max_w) begin
            status_next = ST_BAD_LEN;
        end else if (!start_ok_next || s_rx_byte != END_BYTE) begin
            status_next = ST_BAD_DELIM;
        end else if (fault_at_end) begin
            status_next = ST_BAD_ESC;
        end else if (dec_count_next < 3'(PAY_N)) begin
            status_next = ST_TOO_FEW;
        end else if (payload_next[3] != sum) begin
            status_next = ST_BAD_CHKSUM;
        end else begin
            status_next = ST_OK;
        end
    end

    // limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= MIN_LEN_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MIN_LEN: min_len_reg <= cfg_data;
                CFG_MAX_LEN: max_len_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // frame state: cleared on reset and after every end-of-frame beat
    always_ff @(posedge aclk) begin
        if (!aresetn || (s_beat && s_end_of_frame)) begin
            raw_count_reg   <= '0;
            held_byte_reg   <= '0;
            esc_pending_reg <= 1'b0;
            start_ok_reg    <= 1'b0;
            esc_fault_reg   <= 1'b0;
            dec_count_reg   <= '0;
            for (int i = 0; i < PAY_N; i++) begin
                payload_reg[i] <= '0;
            end
        end else if (s_beat) begin
            raw_count_reg   <= raw_count_next;
            held_byte_reg   <= held_byte_next;
            esc_pending_reg <= esc_pending_next;
            start_ok_reg    <= start_ok_next;
            esc_fault_reg   <= esc_fault_next;
            dec_count_reg   <= dec_count_next;
            for (int i = 0; i < PAY_N; i++) begin
                payload_reg[i] <= payload_next[i];
            end
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_beat && s_end_of_frame) begin
            m_valid_reg <= 1'b1;
        end else if (m_beat) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded only when the slot is free or being emptied
    always_ff @(posedge aclk) begin
        if (s_beat && s_end_of_frame) begin
            status_reg <= status_next;
            for (int i = 0; i < PAY_N; i++) begin
                res_reg[i] <= payload_next[i];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_command_code = res_reg[0];
    assign m_command_arg  = res_reg[1];
    assign m_extra_byte   = res_reg[2];
    assign m_check_byte   = res_reg[3];

endmodule

`default_nettype wire

FILE: rtl/ecfr_checker.sv
// Port-level checker for the escaped command frame receiver, with its bind.
// Depends on ecfr_pkg and escaped_command_frame_receiver_top.
`default_nettype none

module ecfr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       s_end_of_frame,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [2:0] m_status,
    input wire logic [7:0] m_command_code,
    input wire logic [7:0] m_command_arg,
    input wire logic [7:0] m_extra_byte,
    input wire logic [7:0] m_check_byte
);
    import ecfr_pkg::*;

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_check_byte))
        else $error("result changed while stalled");

    // a new result only follows an end-of-frame beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_end_of_frame))
        else $error("result without end-of-frame beat");

    // input side is never blocked by an empty result slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result slot");

    // an accepted frame carries a matching checksum
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |->
            m_check_byte == 8'(m_command_code + m_command_arg + m_extra_byte))
        else $error("ok status with bad checksum");

    // status stays within its defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_BAD_CHKSUM)
        else $error("undefined status code");

endmodule

bind escaped_command_frame_receiver_top ecfr_checker u_ecfr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_end_of_frame (s_end_of_frame),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_command_code (m_command_code),
    .m_command_arg  (m_command_arg),
    .m_extra_byte   (m_extra_byte),
    .m_check_byte   (m_check_byte)
);

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for escaped_command_frame_receiver_top: frame stimulus, unstuffing predictor
// and a result checker. Depends on ecfr_pkg and the receiver top level only.

module tb_top;

    import ecfr_pkg::*;

    // One raw byte beat as queued for the driver
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_beat_t;

    // One frame report as the block should give it
    typedef struct packed {
        status_t    status;
        logic [7:0] code;
        logic [7:0] arg;
        logic [7:0] extra;
        logic [7:0] chk;
    } frame_report_t;

    // Shapes of generated frames; FR_GOOD must stay first (random pick relies on it)
    typedef enum int {
        FR_GOOD,
        FR_BAD_OPEN,
        FR_BAD_CLOSE,
        FR_BAD_ESC,
        FR_ESC_AT_END,
        FR_SHORT,
        FR_NOISE
    } frame_kind_e;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    localparam int N_PHASES       = 8;
    localparam int ITEMS_PER_PHASE = 212;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Block inputs, all known from time zero
    logic             cfg_wr_en      = 1'b0;
    logic             cfg_index      = CFG_MIN_LEN;
    logic [CFG_W-1:0] cfg_data       = '0;
    logic             s_valid        = 1'b0;
    logic [7:0]       s_rx_byte      = 8'h00;
    logic             s_end_of_frame = 1'b0;
    logic             m_ready        = 1'b0;

    // Block outputs
    logic       s_ready;
    logic       m_valid;
    logic [2:0] m_status;
    logic [7:0] m_command_code;
    logic [7:0] m_command_arg;
    logic [7:0] m_extra_byte;
    logic [7:0] m_check_byte;

    // Stimulus and scoreboard storage
    rx_beat_t      rx_beats_pending[$];
    frame_report_t reports_due[$];
    logic [7:0]    raw_frame[$];
    logic          beat_held      = 1'b0;   // a beat sits on the s_ side, not yet taken
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            bad_reports    = 0;

    // Predictor copy of the limits
    logic [CFG_W-1:0] lim_min = MIN_LEN_RESET;
    logic [CFG_W-1:0] lim_max = MAX_LEN_RESET;

    // Predictor copy of the per-frame state
    int         fr_count    = 0;        // raw bytes so far, saturating
    logic [7:0] fr_held     = 8'h00;    // last raw byte, not yet known to be interior
    logic       fr_esc_wait = 1'b0;
    logic       fr_open_ok  = 1'b0;
    logic       fr_esc_bad  = 1'b0;
    int         fr_kept     = 0;        // decoded payload bytes kept, up to 4
    logic [7:0] fr_pay [PAY_N] = '{default: 8'h00};

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    escaped_command_frame_receiver_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_end_of_frame (s_end_of_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_command_code (m_command_code),
        .m_command_arg  (m_command_arg),
        .m_extra_byte   (m_extra_byte),
        .m_check_byte   (m_check_byte)
    );

    // ------------------------------------------------------------------
    // Predictor: advance the unstuffing state by one raw byte. The byte
    // held from the previous beat is only decoded once a later byte shows
    // it was not the closing delimiter. On the marked byte the frame is
    // judged and a report is queued.
    // ------------------------------------------------------------------
    function automatic void unstuff_byte(input logic [7:0] b, input logic last);
        frame_report_t rep;
        logic [7:0]    dec;
        logic          take;
        logic [7:0]    sum;
        dec  = 8'h00;
        take = 1'b0;
        if (fr_count == 0) begin
            fr_open_ok = (b == START_BYTE);
        end else if (fr_count >= 2 && !fr_esc_bad) begin
            if (fr_esc_wait) begin
                fr_esc_wait = 1'b0;
                take        = 1'b1;
                if (fr_held == ESC_TO_7E) begin
                    dec = START_BYTE;
                end else if (fr_held == ESC_TO_7F) begin
                    dec = END_BYTE;
                end else if (fr_held == ESC_TO_7D) begin
                    dec = ESC_BYTE;
                end else begin
                    fr_esc_bad = 1'b1;
                    take       = 1'b0;
                end
            end else if (fr_held == ESC_BYTE) begin
                fr_esc_wait = 1'b1;
            end else begin
                dec  = fr_held;
                take = 1'b1;
            end
            if (take && fr_kept < PAY_N) begin
                fr_pay[fr_kept] = dec;
                fr_kept++;
            end
        end
        if (fr_count < MAX_COUNT_DEF)
            fr_count++;
        fr_held = b;

        if (!last)
            return;

        // dangling escape just before the closing byte
        if (fr_esc_wait) begin
            fr_esc_bad  = 1'b1;
            fr_esc_wait = 1'b0;
        end
        sum = fr_pay[0] + fr_pay[1] + fr_pay[2];

        // first failing check wins: length, delimiters, escape, count, checksum
        if (fr_count < int'(lim_min) || fr_count > int'(lim_max))
            rep.status = ST_BAD_LEN;
        else if (!fr_open_ok || b != END_BYTE)
            rep.status = ST_BAD_DELIM;
        else if (fr_esc_bad)
            rep.status = ST_BAD_ESC;
        else if (fr_kept < PAY_N)
            rep.status = ST_TOO_FEW;
        else if (fr_pay[3] != sum)
            rep.status = ST_BAD_CHKSUM;
        else
            rep.status = ST_OK;
        rep.code  = fr_pay[0];
        rep.arg   = fr_pay[1];
        rep.extra = fr_pay[2];
        rep.chk   = fr_pay[3];
        reports_due.push_back(rep);

        fr_count    = 0;
        fr_held     = 8'h00;
        fr_esc_wait = 1'b0;
        fr_open_ok  = 1'b0;
        fr_esc_bad  = 1'b0;
        fr_kept     = 0;
        fr_pay      = '{default: 8'h00};
    endfunction

    // Random byte leaning on the delimiter, escape and edge values
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) < 30) begin
            case ($urandom_range(7))
                0:       return START_BYTE;
                1:       return END_BYTE;
                2:       return ESC_BYTE;
                3:       return ESC_TO_7E;
                4:       return ESC_TO_7F;
                5:       return ESC_TO_7D;
                6:       return 8'h00;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------
    // Build one raw frame into raw_frame. Well-formed frames carry four
    // stuffed payload bytes, a checksum that is right most of the time, and
    // padding that usually lands the length inside the current window.
    // The other kinds break one thing each; noise is just random bytes.
    // ------------------------------------------------------------------
    function automatic void compose_frame(input frame_kind_e kind);
        logic [7:0] pay [PAY_N];
        logic [7:0] b;
        int         n_pay;
        int         bad_at;
        int         body_len;
        int         lo;
        int         hi;
        int         target;
        raw_frame.delete();
        if (kind == FR_NOISE) begin
            target = $urandom_range(40, 1);
            for (int i = 0; i < target; i++)
                raw_frame.push_back(pick_byte());
            return;
        end

        n_pay = (kind == FR_SHORT) ? $urandom_range(PAY_N - 1, 0) : PAY_N;
        for (int i = 0; i < PAY_N - 1; i++)
            pay[i] = pick_byte();
        if ($urandom_range(99) < 85)
            pay[3] = pay[0] + pay[1] + pay[2];
        else
            pay[3] = pick_byte();
        bad_at = $urandom_range(n_pay, 0);

        if (kind == FR_BAD_OPEN) begin
            b = pick_byte();
            if (b == START_BYTE)
                b = ~b;
        end else begin
            b = START_BYTE;
        end
        raw_frame.push_back(b);

        for (int i = 0; i <= n_pay; i++) begin
            if (kind == FR_BAD_ESC && i == bad_at) begin
                raw_frame.push_back(ESC_BYTE);
                do b = pick_byte(); while (b == ESC_TO_7E || b == ESC_TO_7F || b == ESC_TO_7D);
                raw_frame.push_back(b);
            end
            if (i < n_pay) begin
                if (pay[i] == START_BYTE) begin
                    raw_frame.push_back(ESC_BYTE);
                    raw_frame.push_back(ESC_TO_7E);
                end else if (pay[i] == END_BYTE) begin
                    raw_frame.push_back(ESC_BYTE);
                    raw_frame.push_back(ESC_TO_7F);
                end else if (pay[i] == ESC_BYTE) begin
                    raw_frame.push_back(ESC_BYTE);
                    raw_frame.push_back(ESC_TO_7D);
                end else begin
                    raw_frame.push_back(pay[i]);
                end
            end
        end

        // pad to a target length; past 31 exercises the saturating count
        body_len = raw_frame.size() + ((kind == FR_ESC_AT_END) ? 2 : 1);
        if (kind != FR_SHORT) begin
            lo = int'(lim_min);
            hi = int'(lim_max);
            if (lo < body_len)
                lo = body_len;
            if (lo <= hi && $urandom_range(99) < 80)
                target = $urandom_range(hi, lo);
            else
                target = $urandom_range(36, body_len);
            repeat (target - body_len) begin
                b = 8'($urandom_range(255));
                if (b == ESC_BYTE)
                    b = 8'h00;
                raw_frame.push_back(b);
            end
        end
        if (kind == FR_ESC_AT_END)
            raw_frame.push_back(ESC_BYTE);

        if (kind == FR_BAD_CLOSE) begin
            b = pick_byte();
            if (b == END_BYTE)
                b = ~b;
        end else begin
            b = END_BYTE;
        end
        raw_frame.push_back(b);
    endfunction

    task automatic queue_beat(input logic [7:0] data, input logic last);
        rx_beat_t bt;
        bt.data = data;
        bt.last = last;
        rx_beats_pending.push_back(bt);
    endtask

    // Random frames until roughly n_items beats are queued; mostly well-formed
    task automatic queue_random_frames(input int n_items);
        int          added;
        frame_kind_e kind;
        added = 0;
        while (added < n_items) begin
            if ($urandom_range(99) < 72)
                kind = FR_GOOD;
            else
                kind = frame_kind_e'($urandom_range(FR_NOISE, FR_BAD_OPEN));
            compose_frame(kind);
            foreach (raw_frame[i])
                queue_beat(raw_frame[i], i == raw_frame.size() - 1);
            added += raw_frame.size();
        end
    endtask

    // Limit write while the block is idle
    task automatic write_limit(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_MIN_LEN)
            lim_min = val;
        else
            lim_max = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait for every beat to be taken and every report to come back,
    // then let the registered result path settle
    task automatic wait_drained();
        while (rx_beats_pending.size() != 0 || beat_held || reports_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Beat driver. Valid is only dropped or replaced once the current beat
    // has been taken; the taken beat goes to the predictor in the same
    // process, so the pending/held/expected bookkeeping moves as one.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : beat_driver
        rx_beat_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                unstuff_byte(s_rx_byte, s_end_of_frame);
                beat_held = 1'b0;
            end
            if (rx_beats_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = rx_beats_pending.pop_front();
                s_valid        <= 1'b1;
                s_rx_byte      <= nxt.data;
                s_end_of_frame <= nxt.last;
                beat_held = 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Report monitor: every taken report is matched against the oldest
    // expectation. Back-pressure on m_ready is drawn fresh each cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : report_monitor
        frame_report_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    bad_reports++;
                    if (bad_reports <= 10)
                        $display("%0t: unexpected report status %0d bytes %h %h %h %h",
                                 $realtime, m_status, m_command_code, m_command_arg,
                                 m_extra_byte, m_check_byte);
                end else begin
                    want = reports_due.pop_front();
                    if (m_status !== want.status || m_command_code !== want.code
                        || m_command_arg !== want.arg || m_extra_byte !== want.extra
                        || m_check_byte !== want.chk) begin
                        bad_reports++;
                        if (bad_reports <= 10)
                            $display({"%0t: report differs: exp st %0d %h %h %h %h,",
                                      " got st %0d %h %h %h %h"},
                                     $realtime, want.status, want.code, want.arg, want.extra,
                                     want.chk, m_status, m_command_code, m_command_arg,
                                     m_extra_byte, m_check_byte);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, then phases of limits and idling. Limits are
    // only touched between phases with the block drained.
    // ------------------------------------------------------------------
    initial begin : main_sequence
        logic [CFG_W-1:0] lo_v;
        logic [CFG_W-1:0] hi_v;
        idle_mode_e       mode;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       begin lo_v = MIN_LEN_RESET; hi_v = MAX_LEN_RESET; mode = IDLE_NONE;     end
                1:       begin lo_v = 5'd1;  hi_v = 5'd31; mode = IDLE_SENDER;   end
                2:       begin lo_v = 5'd31; hi_v = 5'd31; mode = IDLE_RECEIVER; end
                3:       begin lo_v = 5'd1;  hi_v = 5'd1;  mode = IDLE_BOTH;     end
                4:       begin lo_v = 5'd20; hi_v = 5'd5;  mode = IDLE_NONE;     end
                5:       begin
                    lo_v = CFG_W'($urandom_range(31, 1));
                    hi_v = CFG_W'($urandom_range(31, 1));
                    mode = IDLE_SENDER;
                end
                6:       begin lo_v = 5'd6;  hi_v = 5'd12; mode = IDLE_RECEIVER; end
                default: begin lo_v = 5'd4;  hi_v = 5'd31; mode = IDLE_BOTH;     end
            endcase

            // phase 0 runs on the reset limits
            if (ph != 0) begin
                write_limit(CFG_MIN_LEN, lo_v);
                write_limit(CFG_MAX_LEN, hi_v);
            end

            case (mode)
                IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 58; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default:       begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            endcase

            if (ph == 0) begin
                // all three escapes, longest allowed length, good checksum 0x7A
                queue_beat(START_BYTE, 1'b0);
                queue_beat(ESC_BYTE, 1'b0);
                queue_beat(ESC_TO_7E, 1'b0);
                queue_beat(ESC_BYTE, 1'b0);
                queue_beat(ESC_TO_7F, 1'b0);
                queue_beat(ESC_BYTE, 1'b0);
                queue_beat(ESC_TO_7D, 1'b0);
                queue_beat(8'h7A, 1'b0);
                queue_beat(END_BYTE, 1'b1);
                // shortest allowed length, all-ones bytes, checksum wrong
                queue_beat(START_BYTE, 1'b0);
                queue_beat(8'hFF, 1'b0);
                queue_beat(8'hFF, 1'b0);
                queue_beat(8'hFF, 1'b0);
                queue_beat(8'h00, 1'b0);
                queue_beat(END_BYTE, 1'b1);
                // escape left hanging just before the closing byte
                queue_beat(START_BYTE, 1'b0);
                queue_beat(8'h01, 1'b0);
                queue_beat(8'h02, 1'b0);
                queue_beat(8'h03, 1'b0);
                queue_beat(ESC_BYTE, 1'b0);
                queue_beat(END_BYTE, 1'b1);
                // lone closing byte: too short for the reset window
                queue_beat(END_BYTE, 1'b1);
            end else if (ph == 3) begin
                // one-byte frame passes length, so delimiters must fail
                queue_beat(START_BYTE, 1'b1);
            end

            queue_random_frames(ITEMS_PER_PHASE);
            wait_drained();
        end

        if (bad_reports == 0 && reports_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: escaped_command_frame_receiver_top.f
rtl/ecfr_pkg.sv
rtl/escaped_command_frame_receiver_top.sv
rtl/ecfr_checker.sv
test/tb_top.sv
